// ===== src/u8ss_pkg.sv =====
// ----------------------------------------------------------------------------
// u8ss_pkg
// Shared types and constants of the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
package u8ss_pkg;

  localparam int COUNT_BITS_DEF = 32;

  localparam logic [1:0] REQ_DATA     = 2'd0;
  localparam logic [1:0] REQ_DATA_EOS = 2'd1;

  localparam logic [7:0] REPL_CHAR = 8'h3F;

  localparam logic [10:0] FLOOR_2B    = 11'h080;
  localparam logic [15:0] FLOOR_3B    = 16'h0800;
  localparam logic [15:0] SURR_LO     = 16'hD800;
  localparam logic [15:0] SURR_HI     = 16'hDFFF;
  localparam logic [20:0] FLOOR_4B    = 21'h010000;
  localparam logic [20:0] MAX_CODEPT  = 21'h10FFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        was_replaced;
    logic        last_of_run;
    logic [31:0] invalid_total;
  } out_item_t;

  typedef logic [3:0][7:0] byte_buf_t;

  typedef enum logic [1:0] {
    SCAN_INCOMPLETE,
    SCAN_INVALID,
    SCAN_VALID
  } scan_kind_t;

  typedef struct packed {
    scan_kind_t kind;
    logic [2:0] len;
  } scan_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

// ===== src/utf8_stream_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Checks a byte stream as UTF-8 and replaces invalid sequences with '?'.
// ----------------------------------------------------------------------------
// One request is taken while the block is idle; the sequencer then resolves
// the buffered bytes one result per cycle, while the output side does not stall,
// through a single sequence scanner, and then closes the run. The next
// request is taken only once the run has closed. Up to three bytes of an
// unfinished sequence are held between requests; results leave through an
// output register so the run continues while one result waits to be taken.
module utf8_stream_sanitizer import u8ss_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  state_t    state_r, state_nxt;
  byte_buf_t buf_r, buf_nxt;
  logic [2:0] have_r, have_nxt;
  logic       flush_r, flush_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic       pend_v_r, pend_v_nxt;
  out_item_t  pend_r, pend_nxt;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r, out_nxt;

  scan_res_t             scan;
  logic                  cnt_inc;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  advance;
  logic                  stop;

  u8ss_scan u_scan (
    .buf_i  (buf_r),
    .have_i (have_r),
    .res_o  (scan)
  );

  u8ss_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .inc_i     (cnt_inc),
    .cnt_nxt_o (cnt_nxt)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // pending result may move on when the output register is free
  assign advance = !pend_v_r || !out_v_r || !out_stall;
  assign stop    = (pass_r == 2'd0) &&
                   ((have_r == 3'd0) || ((scan.kind == SCAN_INCOMPLETE) && !flush_r));

  always_comb begin
    state_nxt  = state_r;
    buf_nxt    = buf_r;
    have_nxt   = have_r;
    flush_nxt  = flush_r;
    pass_nxt   = pass_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && out_stall;
    out_nxt    = out_r;
    cnt_inc    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.req_type == REQ_DATA) || (in_data.req_type == REQ_DATA_EOS)) begin
            buf_nxt[have_r[1:0]] = in_data.data_byte;
            have_nxt             = have_r + 3'd1;
          end
          flush_nxt = (in_data.req_type != REQ_DATA);
          pass_nxt  = 2'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (pend_v_r) begin
            out_nxt             = pend_r;
            out_nxt.last_of_run = stop;
            out_v_nxt           = 1'b1;
            pend_v_nxt          = 1'b0;
          end
          if (stop) begin
            state_nxt = ST_IDLE;
          end else begin
            pend_v_nxt            = 1'b1;
            pend_nxt.last_of_run  = 1'b0;
            pend_nxt.out_byte     = buf_r[0];
            pend_nxt.was_replaced = 1'b0;
            if (pass_r != 2'd0) begin
              // rest of a sequence already judged valid
              pass_nxt = pass_r - 2'd1;
            end else if (scan.kind == SCAN_VALID) begin
              pass_nxt = 2'(scan.len - 3'd1);
            end else begin
              pend_nxt.out_byte     = REPL_CHAR;
              pend_nxt.was_replaced = 1'b1;
              cnt_inc               = 1'b1;
            end
            pend_nxt.invalid_total = 32'(cnt_nxt);
            buf_nxt[0] = buf_r[1];
            buf_nxt[1] = buf_r[2];
            buf_nxt[2] = buf_r[3];
            have_nxt   = have_r - 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      have_r   <= 3'd0;
      flush_r  <= 1'b0;
      pass_r   <= 2'd0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      have_r   <= have_nxt;
      flush_r  <= flush_nxt;
      pass_r   <= pass_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!pend_v_r && (have_r <= 3'd3) && (pass_r == 2'd0)))
    else $error("idle with unresolved work");

  a_have_bound: assert property (@(posedge clk) disable iff (!rst_n)
    have_r <= 3'd4)
    else $error("buffer count out of range");

  a_repl_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.was_replaced) |-> (out_r.out_byte == REPL_CHAR))
    else $error("replacement result without replacement byte");

  a_pass_no_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && advance && pass_r != 2'd0) |=> !cnt_inc || pass_r == 2'd0 ||
    !pend_v_r || !pend_r.was_replaced)
    else $error("replacement inside a valid sequence");
`endif

endmodule

// ===== src/u8ss_scan.sv =====
// ----------------------------------------------------------------------------
// u8ss_scan
// Classifies the sequence at the front of the byte buffer: valid with its
// length, invalid, or still incomplete.
// ----------------------------------------------------------------------------
module u8ss_scan import u8ss_pkg::*; (
  input  byte_buf_t  buf_i,
  input  logic [2:0] have_i,
  output scan_res_t  res_o
);

  logic [2:0]  need;
  logic        bad_lead;
  logic        cont_ok;
  logic        range_bad;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;

  assign v2 = {buf_i[0][4:0], buf_i[1][5:0]};
  assign v3 = {buf_i[0][3:0], buf_i[1][5:0], buf_i[2][5:0]};
  assign v4 = {buf_i[0][2:0], buf_i[1][5:0], buf_i[2][5:0], buf_i[3][5:0]};

  always_comb begin
    need      = 3'd1;
    bad_lead  = 1'b0;
    cont_ok   = 1'b1;
    range_bad = 1'b0;
    if (!buf_i[0][7]) begin
      need = 3'd1;
    end else if (buf_i[0][7:5] == 3'b110) begin
      need      = 3'd2;
      cont_ok   = (buf_i[1][7:6] == 2'b10);
      range_bad = (v2 < FLOOR_2B);
    end else if (buf_i[0][7:4] == 4'b1110) begin
      need      = 3'd3;
      cont_ok   = (buf_i[1][7:6] == 2'b10) && (buf_i[2][7:6] == 2'b10);
      range_bad = (v3 < FLOOR_3B) || ((v3 >= SURR_LO) && (v3 <= SURR_HI));
    end else if (buf_i[0][7:3] == 5'b11110) begin
      need      = 3'd4;
      cont_ok   = (buf_i[1][7:6] == 2'b10) && (buf_i[2][7:6] == 2'b10) &&
                  (buf_i[3][7:6] == 2'b10);
      range_bad = (v4 < FLOOR_4B) || (v4 > MAX_CODEPT);
    end else begin
      bad_lead = 1'b1;
    end

    res_o.len = need;
    if (have_i == 3'd0) begin
      res_o.kind = SCAN_INCOMPLETE;
    end else if (bad_lead) begin
      res_o.kind = SCAN_INVALID;
    end else if (have_i < need) begin
      res_o.kind = SCAN_INCOMPLETE;
    end else if (!cont_ok || range_bad) begin
      res_o.kind = SCAN_INVALID;
    end else begin
      res_o.kind = SCAN_VALID;
    end
  end

endmodule

// ===== src/u8ss_sat_cnt.sv =====
// ----------------------------------------------------------------------------
// u8ss_sat_cnt
// Saturating replacement counter; gives the value after this cycle's step.
// ----------------------------------------------------------------------------
module u8ss_sat_cnt import u8ss_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  inc_i,
  output logic [COUNT_BITS-1:0] cnt_nxt_o
);

  logic [COUNT_BITS-1:0] cnt_r;

  assign cnt_nxt_o = (inc_i && !(&cnt_r)) ? cnt_r + {{(COUNT_BITS-1){1'b0}}, 1'b1} : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt_o;
    end
  end

endmodule
